>>> sv/skdr_pkg.sv
package skdr_pkg;

  localparam int KEY_W     = 4;
  localparam int CNT_W     = 8;
  localparam int STATUS_W  = 32;
  localparam int CODE_W    = 2;
  localparam int CODE_KEYS = STATUS_W / CODE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD   = 2'd1;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd4;
  localparam logic [CNT_W-1:0] PERIOD_RESET    = 8'd0;

  typedef enum logic [CODE_W-1:0] {
    CODE_IDLE = 2'd0,
    CODE_DOWN = 2'd1,
    CODE_UP   = 2'd2,
    CODE_AUTO = 2'd3
  } key_code_t;

  // per-key counters kept in the state ram
  typedef struct packed {
    logic [CNT_W-1:0] stable_cnt;
    logic [CNT_W-1:0] repeat_cnt;
  } key_cnt_t;

  localparam int KEY_CNT_W = $bits(key_cnt_t);

endpackage

>>> sv/scanned_key_debounce_repeat_top.sv
// keypad debouncer with auto-repeat, one scan tick per input beat
//
// input channel (in_valid/in_ready): key_number plus that key's raw level
// key_down. a key number at or above NUM_KEYS is taken and dropped.
// output channel (out_valid/out_ready): status_word, two bits per key
// (inactive, pressed, released, repeat), sent only on the tick for the
// last key when something changed since the last word went out.
// config port: cfg_we/cfg_index/cfg_data, index 0 press threshold,
// index 1 repeat period, other indexes ignored; write only while idle.
//
// one beat per cycle sustained. a tick is looked up in the counter ram in
// the accept cycle and its update is written back from the evaluate stage,
// which also registers the status word that the tick causes.
// a back-to-back tick for the same key takes the just-written counters
// from a bypass register.
// while out_valid waits on out_ready ticks keep flowing; only a tick that
// must send a second word stalls, and then in_ready drops until the held
// word is taken.
// reset clears the debounce state, flags and registers at once: each ram
// entry has a valid bit, so no clearing pass is needed.
module scanned_key_debounce_repeat_top #(
  parameter int NUM_KEYS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [skdr_pkg::KEY_W-1:0]          key_number,
  input  logic                                key_down,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [skdr_pkg::STATUS_W-1:0]       status_word,
  input  logic                                cfg_we,
  input  logic [skdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skdr_pkg::CFG_W-1:0]          cfg_data
);

  import skdr_pkg::*;

  localparam int IDX_W = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;
  // keys past what the status word can carry are dropped from it
  localparam int SHOWN = NUM_KEYS < CODE_KEYS ? NUM_KEYS : CODE_KEYS;
  localparam logic [IDX_W-1:0] LAST_KEY = IDX_W'(NUM_KEYS - 1);

  // configuration
  logic [CNT_W-1:0] press_threshold;
  logic [CNT_W-1:0] repeat_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= THRESHOLD_RESET;
      repeat_period   <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_THRESHOLD: press_threshold <= cfg_data;
        REG_REPEAT_PERIOD:   repeat_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  logic             in_acc;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;

  assign in_acc   = in_valid && in_ready;
  assign in_range = 32'(key_number) < NUM_KEYS;
  assign in_idx   = IDX_W'(key_number);

  // evaluate stage
  logic             s1_valid;
  logic             s1_fire;
  logic [IDX_W-1:0] s1_key;
  logic             s1_down;
  logic             s1_byp;
  key_cnt_t         s1_byp_data;
  logic             s1_ok;

  // state outside the ram
  logic [NUM_KEYS-1:0] ram_valid;
  logic [NUM_KEYS-1:0] debounced;
  logic [NUM_KEYS-1:0] repeating;
  logic                pending;
  logic [STATUS_W-1:0] last_status;

  // next values from the evaluate stage
  key_cnt_t            ram_rdata;
  key_cnt_t            cur;
  key_cnt_t            wr_data;
  logic [NUM_KEYS-1:0] debounced_next;
  logic [NUM_KEYS-1:0] repeating_next;
  logic                pending_next;
  logic                emit;
  logic [STATUS_W-1:0] status_next;

  // a second word may not overwrite one that is still waiting
  assign s1_fire  = s1_valid && !(emit && out_valid && !out_ready);
  assign in_ready = !s1_valid || s1_fire;

  skdr_ram #(
    .WIDTH (KEY_CNT_W),
    .DEPTH (NUM_KEYS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_key),
    .wdata (wr_data),
    .re    (in_acc && in_range),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_acc && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_range) begin
      s1_key      <= in_idx;
      s1_down     <= key_down;
      // the ram read here misses a write to the same entry in this cycle
      s1_byp      <= s1_fire && (s1_key == in_idx);
      s1_byp_data <= wr_data;
      s1_ok       <= ram_valid[in_idx];
    end
  end

  // read-modify-write of one key
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] rcnt;
    logic             dd;
    logic             rf;
    logic             chg;
    logic [CNT_W-1:0] rdec;

    cur  = s1_byp ? s1_byp_data : (s1_ok ? ram_rdata : '0);
    cnt  = cur.stable_cnt;
    rcnt = cur.repeat_cnt;
    dd   = debounced[s1_key];
    rf   = repeating[s1_key];
    chg  = 1'b0;
    rdec = rcnt - 1'b1;

    if (s1_down) begin
      if (cnt < press_threshold) begin
        cnt = cnt + 1'b1;
      end
    end else if (cnt != '0) begin
      cnt = cnt - 1'b1;
    end

    if (s1_down != dd) begin
      if (s1_down && cnt == press_threshold) begin
        dd   = 1'b1;
        chg  = 1'b1;
        rcnt = repeat_period;
      end else if (!s1_down && cnt == '0) begin
        dd   = 1'b0;
        chg  = 1'b1;
        rcnt = '0;
        rf   = 1'b0;
      end
    end else if (rcnt != '0) begin
      if (rdec == '0) begin
        rf   = 1'b1;
        chg  = 1'b1;
        rcnt = repeat_period;
      end else begin
        rcnt = rdec;
      end
    end

    wr_data.stable_cnt     = cnt;
    wr_data.repeat_cnt     = rcnt;
    debounced_next         = debounced;
    repeating_next         = repeating;
    debounced_next[s1_key] = dd;
    repeating_next[s1_key] = rf;
    pending_next           = pending || chg;
    emit                   = pending_next && (s1_key == LAST_KEY);
  end

  // packed status word from the updated flags
  always_comb begin
    key_code_t old;
    key_code_t code;
    status_next = '0;
    for (int k = 0; k < SHOWN; k++) begin
      old = key_code_t'(last_status[CODE_W*k +: CODE_W]);
      if (repeating_next[k]) begin
        code = CODE_AUTO;
      end else if (debounced_next[k]) begin
        code = CODE_DOWN;
      end else if (old == CODE_DOWN || old == CODE_AUTO) begin
        code = CODE_UP;
      end else begin
        code = CODE_IDLE;
      end
      status_next[CODE_W*k +: CODE_W] = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_valid   <= '0;
      debounced   <= '0;
      repeating   <= '0;
      pending     <= 1'b0;
      last_status <= '0;
    end else if (s1_fire) begin
      ram_valid[s1_key] <= 1'b1;
      debounced         <= debounced_next;
      repeating         <= repeating_next;
      pending           <= pending_next && !emit;
      if (emit) begin
        last_status <= status_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      status_word <= status_next;
    end
  end

endmodule

>>> sv/skdr_ram.sv
module skdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/skdr_checker.sv
module skdr_checker #(
  parameter int NUM_KEYS = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [skdr_pkg::KEY_W-1:0]          key_number,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [skdr_pkg::STATUS_W-1:0]       status_word
);

  import skdr_pkg::*;

  // a fresh word follows an accepted tick for the last key
  a_word_after_last_key: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready &&
                               (32'(key_number) == NUM_KEYS - 1), 2))
    else $error("status word without a last-key tick");

  // ticks are never held off while the output is empty
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a waiting word holds
  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_word))
    else $error("status word changed while stalled");

  // nothing goes out while reset is held
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind scanned_key_debounce_repeat_top skdr_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_skdr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .key_number  (key_number),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status_word (status_word)
);

>>> dv/scanned_key_debounce_repeat_top_test.sv
`timescale 1ns / 100ps

module scanned_key_debounce_repeat_top_test;
  import skdr_pkg::*;

  localparam int NUM_KEYS      = 16;
  localparam int RAND_TICKS    = 1350;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 6;

  // indexes past the two real registers, the block must drop these writes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // per-key debounce state mirrored in the testbench, plus the queue of
  // status words still owed by the block
  class debounce_scoreboard;
    logic [CNT_W-1:0]    threshold;
    logic [CNT_W-1:0]    period;
    logic [CNT_W-1:0]    stable_cnt [NUM_KEYS];
    logic                debounced  [NUM_KEYS];
    logic [CNT_W-1:0]    rep_cnt    [NUM_KEYS];
    logic                rep_flag   [NUM_KEYS];
    logic                pending;
    logic [STATUS_W-1:0] last_word;
    logic [STATUS_W-1:0] expected_words [$];
    int                  failures;

    function new();
      threshold = THRESHOLD_RESET;
      period    = PERIOD_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        stable_cnt[k] = '0;
        debounced[k]  = 1'b0;
        rep_cnt[k]    = '0;
        rep_flag[k]   = 1'b0;
      end
      pending   = 1'b0;
      last_word = '0;
      failures  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PRESS_THRESHOLD: threshold = data;
        REG_REPEAT_PERIOD:   period = data;
        default: ;
      endcase
    endfunction

    function logic [STATUS_W-1:0] packed_status();
      logic [STATUS_W-1:0] word;
      key_code_t           prior;
      key_code_t           code;
      word = '0;
      for (int k = 0; k < NUM_KEYS && k < CODE_KEYS; k++) begin
        prior = key_code_t'(last_word[CODE_W*k +: CODE_W]);
        if (rep_flag[k]) code = CODE_AUTO;
        else if (debounced[k]) code = CODE_DOWN;
        else if (prior == CODE_DOWN || prior == CODE_AUTO) code = CODE_UP;
        else code = CODE_IDLE;
        word[CODE_W*k +: CODE_W] = code;
      end
      return word;
    endfunction

    // one accepted scan tick
    function void note_tick(logic [KEY_W-1:0] key, logic down);
      int k;
      k = int'(key);
      if (k >= NUM_KEYS) return;
      if (down) begin
        if (stable_cnt[k] < threshold) stable_cnt[k]++;
      end else if (stable_cnt[k] > 0) begin
        stable_cnt[k]--;
      end
      if (down != debounced[k]) begin
        if (down && stable_cnt[k] == threshold) begin
          debounced[k] = 1'b1;
          pending      = 1'b1;
          rep_cnt[k]   = period;
        end else if (!down && stable_cnt[k] == 0) begin
          debounced[k] = 1'b0;
          pending      = 1'b1;
          rep_cnt[k]   = '0;
          rep_flag[k]  = 1'b0;
        end
      end else if (rep_cnt[k] != 0) begin
        rep_cnt[k]--;
        if (rep_cnt[k] == 0) begin
          rep_flag[k] = 1'b1;
          pending     = 1'b1;
          rep_cnt[k]  = period;
        end
      end
      if (pending && k == NUM_KEYS - 1) begin
        pending   = 1'b0;
        last_word = packed_status();
        expected_words.push_back(last_word);
      end
    endfunction

    function void check_word(logic [STATUS_W-1:0] actual);
      logic [STATUS_W-1:0] want;
      if (expected_words.size() == 0) begin
        $error("status_word: expected none, actual %08h", actual);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (actual !== want) begin
        $error("status_word: expected %08h, actual %08h", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [KEY_W-1:0]     key_number  = '0;
  logic                 key_down    = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [STATUS_W-1:0]  status_word;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;

  debounce_scoreboard sb;

  int tick_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // intended contact level per key, the raw samples bounce around it
  bit held [NUM_KEYS];

  // press threshold, repeat period and random tick budget of each phase;
  // phase 0 runs on the reset values
  int unsigned phase_thr [NUM_PHASES] = '{4, 1, 3, 255, 0, 6};
  int unsigned phase_per [NUM_PHASES] = '{0, 1, 2, 255, 5, 3};
  int          phase_len [NUM_PHASES] = '{150, 200, 250, 250, 150, 250};

  scanned_key_debounce_repeat_top #(
    .NUM_KEYS(NUM_KEYS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_number (key_number),
    .key_down   (key_down),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status_word(status_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, every status beat is checked at the edge it is taken
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) sb.check_word(status_word);
  end

  // one scan tick beat; valid stays up across back-to-back beats
  task automatic send_tick(input logic [KEY_W-1:0] k, input logic d);
    // idle mix: sender light and receiver heavy, then swapped, then none
    if (tick_count < RAND_TICKS / 3) begin
      send_idle_pct = 37;
      recv_idle_pct = 81;
    end else if (tick_count < 2 * RAND_TICKS / 3) begin
      send_idle_pct = 81;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    key_number <= k;
    key_down   <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(k, d);
    tick_count++;
  endtask

  // hold off the sender until every owed word is out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes back to back, we held high across them
  task automatic configure(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] per,
                           input bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESS_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    sb.write_reg(REG_PRESS_THRESHOLD, thr);
    cfg_index <= REG_REPEAT_PERIOD;
    cfg_data  <= per;
    @(posedge clk);
    sb.write_reg(REG_REPEAT_PERIOD, per);
    if (spare) begin
      cfg_index <= REG_SPARE_2;
      cfg_data  <= 8'hff;
      @(posedge clk);
      cfg_index <= REG_SPARE_3;
      cfg_data  <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // a scan over the first n keys in order; n below NUM_KEYS is a broken pass
  task automatic scan_pass(input int n);
    logic lvl;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 12) held[k] = !held[k];
      lvl = held[k] ^ ($urandom_range(0, 99) < 10);
      send_tick(KEY_W'(k), lvl);
    end
  endtask

  task automatic random_chunk();
    int   pick;
    int   n;
    int   k;
    logic lvl;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      scan_pass(NUM_KEYS);
    end else if (pick < 75) begin
      scan_pass($urandom_range(1, NUM_KEYS - 1));
    end else if (pick < 90) begin
      // one key sampled over and over: reaches high thresholds and long repeats
      k = ($urandom_range(0, 3) == 0) ? NUM_KEYS - 1 : $urandom_range(0, NUM_KEYS - 1);
      if ($urandom_range(0, 1)) held[k] = !held[k];
      if ($urandom_range(0, 1))
        n = int'(sb.threshold) + $urandom_range(0, int'(sb.period) + 6);
      else
        n = $urandom_range(1, int'(sb.threshold) + int'(sb.period) + 6);
      repeat (n) begin
        lvl = held[k] ^ ($urandom_range(0, 99) < 3);
        send_tick(KEY_W'(k), lvl);
      end
    end else begin
      send_tick(KEY_W'($urandom_range(0, NUM_KEYS - 1)), $urandom_range(0, 1));
    end
  endtask

  initial begin
    int phase_start;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks on the reset settings (threshold 4, repeat off)
    repeat (4) send_tick(4'd0, 1'b1);   // key 0 settles pressed
    send_tick(4'(NUM_KEYS - 1), 1'b0);  // last key tick sends key 0 pressed
    send_tick(4'd3, 1'b1);              // bounce on key 3, never stable
    send_tick(4'd3, 1'b0);
    send_tick(4'd3, 1'b1);
    repeat (4) send_tick(4'(NUM_KEYS - 1), 1'b1);  // last key pressed, word on its own tick
    repeat (4) send_tick(4'd0, 1'b0);   // key 0 released
    send_tick(4'(NUM_KEYS - 1), 1'b1);  // released code for key 0
    send_tick(4'(NUM_KEYS - 1), 1'b1);  // nothing changed, no word
    repeat (4) send_tick(4'(NUM_KEYS - 1), 1'b0);  // last key released

    // random phases; each setting change waits for the block to go quiet,
    // and moving from 255 down to 0 leaves counters above the new threshold
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        configure(CFG_W'(phase_thr[p]), CFG_W'(phase_per[p]), p == 2);
      end
      phase_start = tick_count;
      while (tick_count - phase_start < phase_len[p]) random_chunk();
    end

    wait_idle();
    if (sb.failures == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // hang guard, far past the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
sv/skdr_pkg.sv
sv/skdr_ram.sv
sv/scanned_key_debounce_repeat_top.sv
sv/skdr_checker.sv
dv/scanned_key_debounce_repeat_top_test.sv
